// ===== rtl/qetc_pkg.sv =====
`timescale 1ns / 1ps

package qetc_pkg;

  // Decoder phase codes of the full-step table
  localparam logic [2:0] PhStart    = 3'h0;
  localparam logic [2:0] PhCwFinal  = 3'h1;
  localparam logic [2:0] PhCwBegin  = 3'h2;
  localparam logic [2:0] PhCwNext   = 3'h3;
  localparam logic [2:0] PhCcwBegin = 3'h4;
  localparam logic [2:0] PhCcwFinal = 3'h5;
  localparam logic [2:0] PhCcwNext  = 3'h6;

  // step_event codes
  localparam logic [1:0] StepNone = 2'd0;
  localparam logic [1:0] StepCw   = 2'd1;
  localparam logic [1:0] StepCcw  = 2'd2;

  // Register indexes
  localparam logic RegInvert = 1'b0;
  localparam logic RegButton = 1'b1;

  localparam logic signed [15:0] TickMax = 16'sh7fff;
  localparam logic signed [15:0] TickMin = -16'sh8000;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic button_level;
    logic take_ticks;
    logic take_press;
  } qetc_in_t;

  typedef struct packed {
    logic signed [15:0] tick_total;
    logic               pressed;
    logic               changed;
    logic [1:0]         step_event;
  } qetc_out_t;

  typedef struct packed {
    logic invert_direction;
    logic button_present;
  } qetc_cfg_t;

  // Table entry: emit ccw, emit cw, next phase
  typedef struct packed {
    logic       emit_ccw;
    logic       emit_cw;
    logic [2:0] phase;
  } qetc_entry_t;

  // Transition table indexed by {phase, pin_b, pin_a}
  function automatic qetc_entry_t next_entry(input logic [2:0] phase, input logic b,
                                             input logic a);
    qetc_entry_t e;
    e = '{emit_ccw: 1'b0, emit_cw: 1'b0, phase: PhStart};
    case (phase)
      PhCwFinal: begin
        case ({b, a})
          2'b00:   e.phase = PhCwNext;
          2'b01:   e.phase = PhStart;
          2'b10:   e.phase = PhCwFinal;
          default: e.emit_cw = 1'b1;
        endcase
      end
      PhCwBegin: begin
        case ({b, a})
          2'b00:   e.phase = PhCwNext;
          2'b01:   e.phase = PhCwBegin;
          default: e.phase = PhStart;
        endcase
      end
      PhCwNext: begin
        case ({b, a})
          2'b00:   e.phase = PhCwNext;
          2'b01:   e.phase = PhCwBegin;
          2'b10:   e.phase = PhCwFinal;
          default: e.phase = PhStart;
        endcase
      end
      PhCcwBegin: begin
        case ({b, a})
          2'b00:   e.phase = PhCcwNext;
          2'b10:   e.phase = PhCcwBegin;
          default: e.phase = PhStart;
        endcase
      end
      PhCcwFinal: begin
        case ({b, a})
          2'b00:   e.phase = PhCcwNext;
          2'b01:   e.phase = PhCcwFinal;
          2'b10:   e.phase = PhStart;
          default: e.emit_ccw = 1'b1;
        endcase
      end
      PhCcwNext: begin
        case ({b, a})
          2'b00:   e.phase = PhCcwNext;
          2'b01:   e.phase = PhCcwFinal;
          2'b10:   e.phase = PhCcwBegin;
          default: e.phase = PhStart;
        endcase
      end
      // start state, and the unused code
      default: begin
        case ({b, a})
          2'b01:   e.phase = PhCwBegin;
          2'b10:   e.phase = PhCcwBegin;
          default: e.phase = PhStart;
        endcase
      end
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/qetc_apb_regs.sv =====
`timescale 1ns / 1ps

module qetc_apb_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output qetc_pkg::qetc_cfg_t cfg_o
);

  qetc_pkg::qetc_cfg_t cfg_q, cfg_d;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        qetc_pkg::RegInvert: cfg_d.invert_direction = pwdata[0];
        qetc_pkg::RegButton: cfg_d.button_present   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      qetc_pkg::RegInvert: prdata = {31'd0, cfg_q.invert_direction};
      qetc_pkg::RegButton: prdata = {31'd0, cfg_q.button_present};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/qetc_core.sv =====
`timescale 1ns / 1ps

module qetc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  qetc_pkg::qetc_in_t  in_i,
  input  qetc_pkg::qetc_cfg_t cfg_i,
  output qetc_pkg::qetc_out_t res_o
);

  logic [2:0]          phase_q, phase_d;
  logic signed [15:0]  tick_q, tick_d;
  logic                flag_q, flag_d;

  qetc_pkg::qetc_entry_t entry;
  logic                  held;
  logic                  inc, dec;
  logic signed [15:0]    tick_new;
  logic                  flag_new;
  logic [1:0]            event_new;

  assign held  = cfg_i.button_present & ~in_i.button_level;
  assign entry = qetc_pkg::next_entry(phase_q, in_i.pin_b, in_i.pin_a);

  // table step, saturating count update
  always_comb begin
    phase_d   = phase_q;
    flag_new  = flag_q;
    event_new = qetc_pkg::StepNone;
    inc       = 1'b0;
    dec       = 1'b0;
    if (held) begin
      flag_new = 1'b1;
    end else begin
      phase_d = entry.phase;
      if (entry.emit_cw) begin
        event_new = qetc_pkg::StepCw;
        inc       = ~cfg_i.invert_direction;
        dec       = cfg_i.invert_direction;
      end else if (entry.emit_ccw) begin
        event_new = qetc_pkg::StepCcw;
        inc       = cfg_i.invert_direction;
        dec       = ~cfg_i.invert_direction;
      end
    end
    tick_new = tick_q;
    if (inc && tick_q != qetc_pkg::TickMax) begin
      tick_new = tick_q + 16'sd1;
    end else if (dec && tick_q != qetc_pkg::TickMin) begin
      tick_new = tick_q - 16'sd1;
    end
    tick_d = in_i.take_ticks ? 16'sd0 : tick_new;
    flag_d = in_i.take_press ? 1'b0 : flag_new;

    res_o.tick_total = tick_new;
    res_o.pressed    = flag_new;
    res_o.changed    = (tick_new != 16'sd0) | flag_new;
    res_o.step_event = event_new;
  end

  // decoder state, updated once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qetc_pkg::PhStart;
      tick_q  <= '0;
      flag_q  <= 1'b0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      flag_q  <= flag_d;
    end
  end

endmodule

// ===== rtl/qetc_out_skid.sv =====
`timescale 1ns / 1ps

module qetc_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  qetc_pkg::qetc_out_t data_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qetc_pkg::qetc_out_t out_data_o
);

  logic                out_valid_q, skid_valid_q;
  qetc_pkg::qetc_out_t out_q, skid_q;

  assign ready_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control: output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (load_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (load_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

// ===== rtl/quadrature_encoder_tick_counter.sv =====
`timescale 1ns / 1ps

// Quadrature encoder detent counter.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat per sample of
// the phase A/B pins and the active-low button, plus acknowledge bits that
// clear the tick count or press flag after this beat's result.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result beat per
// input beat, in order: saturated signed tick total, sticky press flag,
// changed flag and the detent direction seen on this sample.
// Throughput: one beat per cycle while the receiver keeps up. The result is
// registered; the table step and counter update are a single level of logic
// ahead of the output register. When the receiver stalls, one further result
// is held in a skid entry and in_ready_o drops until it drains.
// Reset clears the decoder to its start state, the count, the press flag,
// both configuration registers and all pending results.
// Configuration (APB, always ready): invert_direction at 0x0,
// button_present at 0x4; write only while the block is idle.

module quadrature_encoder_tick_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qetc_pkg::qetc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qetc_pkg::qetc_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  qetc_pkg::qetc_cfg_t cfg;
  qetc_pkg::qetc_out_t res;
  logic                beat;

  assign beat = in_valid_i & in_ready_o;

  qetc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qetc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  qetc_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (beat),
    .data_i      (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
